>>> design/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
`default_nettype none

package rau_pkg;

    localparam int IN_W   = 32;
    localparam int WIDE_W = 64;
    localparam int DEN_W  = 63;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [STAT_W-1:0] status_t;
    typedef logic [WIDE_W-1:0] wide_t;

    localparam func_t FUNC_ADD = 2'd0;
    localparam func_t FUNC_SUB = 2'd1;
    localparam func_t FUNC_MUL = 2'd2;
    localparam func_t FUNC_DIV = 2'd3;

    localparam status_t STAT_OK       = 2'd0;
    localparam status_t STAT_ZERO_DEN = 2'd1;
    localparam status_t STAT_DIV_ZERO = 2'd2;

    localparam wide_t WIDE_ONE = {{(WIDE_W-1){1'b0}}, 1'b1};
    localparam wide_t MAX_MAG  = {1'b0, {(WIDE_W-1){1'b1}}};

endpackage

`default_nettype wire

>>> design/rational_arithmetic_unit.sv
// Rational arithmetic unit top level: sequencer, sign handling and result register.
//
// Adds, subtracts, multiplies or divides two signed fractions and returns the
// result reduced to lowest terms, with a positive denominator and the sign on
// the numerator; a zero result comes back as 0/1. A zero input denominator
// gives status 1, division by a zero fraction gives status 2, and both return
// 0/0. Operands are taken from the low OPERAND_WIDTH bits of each input port.
// One transaction is handled at a time: in_ready is high only while the unit
// is idle, and the result is held on the output until taken. A transaction
// makes three passes through one registered multiplier, then runs a binary
// gcd of the two 64-bit operands in shift and subtract steps and two restoring
// divisions sharing one divider; a zero result skips the gcd and divisions.
// A transaction that hits an error status goes from the check state straight
// to the output state.
`default_nettype none

module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input transaction
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic        [rau_pkg::FUNC_W-1:0]  func,
    input  wire logic signed [rau_pkg::IN_W-1:0]    a_num,
    input  wire logic signed [rau_pkg::IN_W-1:0]    a_den,
    input  wire logic signed [rau_pkg::IN_W-1:0]    b_num,
    input  wire logic signed [rau_pkg::IN_W-1:0]    b_den,
    // result transaction
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed      [rau_pkg::WIDE_W-1:0]  res_num,
    output logic             [rau_pkg::DEN_W-1:0]   res_den,
    output logic             [rau_pkg::STAT_W-1:0]  status
);

    localparam int W  = OPERAND_WIDTH;
    localparam int WW = rau_pkg::WIDE_W;
    localparam logic [W-1:0] ONE_W = W'(1);
    localparam logic [rau_pkg::DEN_W-1:0] DEN_ONE = rau_pkg::DEN_W'(1);

    // one-hot sequencer
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_CHECK = 13'b0000000000010,
        S_MUL0  = 13'b0000000000100,
        S_MUL1  = 13'b0000000001000,
        S_MUL2  = 13'b0000000010000,
        S_COMB  = 13'b0000000100000,
        S_GCD   = 13'b0000001000000,
        S_GCDW  = 13'b0000010000000,
        S_DIVN  = 13'b0000100000000,
        S_DIVNW = 13'b0001000000000,
        S_DIVD  = 13'b0010000000000,
        S_DIVDW = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // operand magnitudes and signs
    logic [W-1:0] an_v, ad_v, bn_v, bd_v;
    logic [W-1:0] an_mag, ad_mag, bn_mag, bd_mag;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic         s_an_reg, s_bn_reg;
    rau_pkg::func_t func_reg;

    // working values
    rau_pkg::wide_t num_reg, den_reg, t_reg;
    logic           neg_reg;
    rau_pkg::wide_t prod;
    rau_pkg::wide_t comb_mag;
    logic           comb_neg;
    logic           add_sub;

    // result register
    logic [WW-1:0]             res_num_reg;
    logic [rau_pkg::DEN_W-1:0] res_den_reg;
    rau_pkg::status_t          status_reg;

    // shared units
    logic [W-1:0]   mul_a, mul_b;
    logic [2*W-1:0] mul_p;
    logic           gcd_start, gcd_done;
    rau_pkg::wide_t gcd_g;
    logic           div_start, div_done;
    rau_pkg::wide_t div_dividend, div_q;
    rau_pkg::wide_t sat_mag;

    assign an_v = a_num[W-1:0];
    assign ad_v = a_den[W-1:0];
    assign bn_v = b_num[W-1:0];
    assign bd_v = b_den[W-1:0];

    // most negative value maps onto its own bit pattern, which is the exact magnitude
    assign an_mag = an_v[W-1] ? (~an_v + ONE_W) : an_v;
    assign ad_mag = ad_v[W-1] ? (~ad_v + ONE_W) : ad_v;
    assign bn_mag = bn_v[W-1] ? (~bn_v + ONE_W) : bn_v;
    assign bd_mag = bd_v[W-1] ? (~bd_v + ONE_W) : bd_v;

    assign add_sub = (func_reg == rau_pkg::FUNC_ADD) || (func_reg == rau_pkg::FUNC_SUB);

    // multiplier operand schedule
    //   MUL0: an*bd (an*bn for multiply)
    //   MUL1: bn*ad for add/sub, ad*bd for multiply, ad*bn for divide
    //   MUL2: ad*bd (add/sub only)
    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        case (state_reg)
            S_MUL0:
            begin
                mul_a = an_reg;
                mul_b = (func_reg == rau_pkg::FUNC_MUL) ? bn_reg : bd_reg;
            end
            S_MUL1:
            begin
                mul_a = ad_reg;
                mul_b = (func_reg == rau_pkg::FUNC_MUL) ? bd_reg : bn_reg;
            end
            S_MUL2:
            begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
            default:
            begin
                mul_a = an_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    rau_mul #(
        .W (W)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign prod = WW'(mul_p);

    // signed-magnitude sum of the two cross products; a zero term takes the
    // other term's sign, so the zero flags need no separate handling
    always_comb
    begin
        if (s_an_reg == s_bn_reg)
        begin
            comb_mag = num_reg + t_reg;
            comb_neg = s_an_reg;
        end
        else if (num_reg >= t_reg)
        begin
            comb_mag = num_reg - t_reg;
            comb_neg = s_an_reg;
        end
        else
        begin
            comb_mag = t_reg - num_reg;
            comb_neg = s_bn_reg;
        end
    end

    assign gcd_start    = (state_reg == S_GCD) && (num_reg != '0);
    assign div_start    = (state_reg == S_DIVN) || (state_reg == S_DIVD);
    assign div_dividend = (state_reg == S_DIVN) ? num_reg : den_reg;

    rau_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .x     (num_reg),
        .y     (den_reg),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    rau_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (gcd_g),
        .done     (div_done),
        .quotient (div_q)
    );

    // reduced numerator never exceeds 2^63-1 in practice; clamp anyway
    assign sat_mag = num_reg[WW-1] ? rau_pkg::MAX_MAG : num_reg;

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_CHECK;
            S_CHECK:
                if (ad_reg == '0 || bd_reg == '0)
                    state_next = S_OUT;
                else if (func_reg == rau_pkg::FUNC_DIV && bn_reg == '0)
                    state_next = S_OUT;
                else
                    state_next = S_MUL0;
            S_MUL0:
                state_next = S_MUL1;
            S_MUL1:
                state_next = S_MUL2;
            S_MUL2:
                state_next = S_COMB;
            S_COMB:
                state_next = S_GCD;
            S_GCD:
                state_next = (num_reg == '0) ? S_OUT : S_GCDW;
            S_GCDW:
                if (gcd_done)
                    state_next = S_DIVN;
            S_DIVN:
                state_next = S_DIVNW;
            S_DIVNW:
                if (div_done)
                    state_next = S_DIVD;
            S_DIVD:
                state_next = S_DIVDW;
            S_DIVDW:
                if (div_done)
                    state_next = S_OUT;
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    an_reg   <= an_mag;
                    ad_reg   <= ad_mag;
                    bn_reg   <= bn_mag;
                    bd_reg   <= bd_mag;
                    func_reg <= func;
                    // denominator sign folded onto the numerator; subtract negates b
                    s_an_reg <= an_v[W-1] ^ ad_v[W-1];
                    s_bn_reg <= bn_v[W-1] ^ bd_v[W-1] ^ (func == rau_pkg::FUNC_SUB);
                end
            S_CHECK:
            begin
                res_num_reg <= '0;
                res_den_reg <= '0;
                if (ad_reg == '0 || bd_reg == '0)
                    status_reg <= rau_pkg::STAT_ZERO_DEN;
                else
                    status_reg <= rau_pkg::STAT_DIV_ZERO;
            end
            S_MUL1:
                num_reg <= prod;
            S_MUL2:
                t_reg <= prod;
            S_COMB:
                if (add_sub)
                begin
                    num_reg <= comb_mag;
                    neg_reg <= comb_neg;
                    den_reg <= prod;
                end
                else
                begin
                    den_reg <= t_reg;
                    neg_reg <= s_an_reg ^ s_bn_reg;
                end
            S_GCD:
                if (num_reg == '0)
                begin
                    res_num_reg <= '0;
                    res_den_reg <= DEN_ONE;
                    status_reg  <= rau_pkg::STAT_OK;
                end
            S_DIVNW:
                if (div_done)
                    num_reg <= div_q;
            S_DIVDW:
                if (div_done)
                begin
                    res_num_reg <= neg_reg ? (~sat_mag + rau_pkg::WIDE_ONE) : sat_mag;
                    res_den_reg <= div_q[rau_pkg::DEN_W-1:0];
                    status_reg  <= rau_pkg::STAT_OK;
                end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign status    = status_reg;

    // checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output sides both open");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready right after an accepted transaction");

    a_ok_has_den: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == rau_pkg::STAT_OK) |-> (res_den != '0))
        else $error("ok result with zero denominator");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != rau_pkg::STAT_OK) |-> (res_num == '0 && res_den == '0))
        else $error("error result with nonzero fields");

endmodule

`default_nettype wire

>>> design/rau_mul.sv
// Magnitude multiplier with registered product.
`default_nettype none

module rau_mul #(
    parameter int W = 32
) (
    input  wire logic           clk,
    input  wire logic [W-1:0]   a,
    input  wire logic [W-1:0]   b,
    output logic      [2*W-1:0] p
);

    logic [2*W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= {{W{1'b0}}, a} * {{W{1'b0}}, b};
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> design/rau_gcd.sv
// Binary gcd unit: one shift or subtract step per cycle.
`default_nettype none

module rau_gcd (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire rau_pkg::wide_t x,
    input  wire rau_pkg::wide_t y,
    output logic               done,
    output rau_pkg::wide_t     g
);

    localparam int K_W = $clog2(rau_pkg::WIDE_W);

    rau_pkg::wide_t x_reg;
    rau_pkg::wide_t y_reg;
    rau_pkg::wide_t g_reg;
    logic [K_W-1:0] k_reg;
    logic           busy_reg;
    logic           done_reg;
    logic           finish;

    assign finish = busy_reg && (x_reg == '0 || y_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= finish;
            if (start)
                busy_reg <= 1'b1;
            else if (finish)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
            y_reg <= y;
            k_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (x_reg == '0)
                g_reg <= y_reg << k_reg;
            else if (y_reg == '0)
                g_reg <= x_reg << k_reg;
            else if (!x_reg[0] && !y_reg[0])
            begin
                // common factor of two
                x_reg <= x_reg >> 1;
                y_reg <= y_reg >> 1;
                k_reg <= k_reg + K_W'(1);
            end
            else if (!x_reg[0])
                x_reg <= x_reg >> 1;
            else if (!y_reg[0])
                y_reg <= y_reg >> 1;
            else if (x_reg >= y_reg)
                x_reg <= x_reg - y_reg;
            else
                y_reg <= y_reg - x_reg;
        end
    end

    assign done = done_reg;
    assign g    = g_reg;

endmodule

`default_nettype wire

>>> design/rau_div.sv
// Restoring divider: one quotient bit per cycle.
`default_nettype none

module rau_div (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire rau_pkg::wide_t dividend,
    input  wire rau_pkg::wide_t divisor,
    output logic               done,
    output rau_pkg::wide_t     quotient
);

    localparam int WW    = rau_pkg::WIDE_W;
    localparam int CNT_W = $clog2(WW);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(WW - 1);

    rau_pkg::wide_t rem_reg;
    rau_pkg::wide_t quo_reg;
    rau_pkg::wide_t dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [WW:0]    shifted;
    logic [WW:0]    trial;
    logic           take;

    assign shifted = {rem_reg, quo_reg[WW-1]};
    assign take    = shifted >= {1'b0, dvs_reg};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && cnt_reg == LAST)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? trial[WW-1:0] : shifted[WW-1:0];
            quo_reg <= {quo_reg[WW-2:0], take};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
